// ===== rtl/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LRU page-replacement tracker.
package lrupr_pkg;

	localparam int ENTRIES = 16;
	localparam int PAGE_W  = 7;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CNT_W   = 32;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index, taken from the word address.
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [OCC_W-1:0]  occ_t;
	typedef logic [CAP_W-1:0]  cap_t;
	typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ===== rtl/lrupr_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: one page reference per request.
interface lrupr_req_if;
	logic                 valid;
	logic                 ready;
	lrupr_pkg::page_t     page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

// ===== rtl/lrupr_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: hit, eviction, counters and occupancy for one reference.
interface lrupr_rsp_if;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 evicted_valid;
	lrupr_pkg::page_t     evicted_page;
	lrupr_pkg::cnt_t      fault_count;
	lrupr_pkg::cnt_t      access_count;
	lrupr_pkg::occ_t      occupancy;

	modport source (
		output valid, output hit, output evicted_valid, output evicted_page,
		output fault_count, output access_count, output occupancy, input ready
	);
	modport sink (
		input valid, input hit, input evicted_valid, input evicted_page,
		input fault_count, input access_count, input occupancy, output ready
	);
endinterface

// ===== rtl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// Top level of the fully associative LRU page-replacement tracker.
//
//  Channel  Dir  Handshake          Contents
//  req      in   valid/ready        page
//  rsp      out  valid/ready        hit, evicted_valid, evicted_page, fault_count,
//                                   access_count, occupancy
//  apb      in   psel/penable       capacity register at byte address 0
//
// One reference per cycle sustained while results are taken; a request passes the input
// register, then the result register. The frame lookup, the LRU pick and the
// rank update all happen between those two registers.
// Reset empties every frame, clears both counters and sets capacity to 16.
// A stalled result holds in the result register; one more request can wait in the
// input register, after which ready drops until the result is taken.
module lru_page_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	lrupr_req_if.sink                      req,
	lrupr_rsp_if.source                    rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lrupr_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrupr_pkg::PDATA_W-1:0]  pwdata,
	output logic [lrupr_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);

	localparam int N = lrupr_pkg::ENTRIES;

	// Configuration.
	lrupr_pkg::cap_t cap_q;
	logic            reg_sel;

	// Frame store.
	lrupr_pkg::page_t frame_page_q [N];
	lrupr_pkg::rank_t rank_q       [N];
	logic [N-1:0]     frame_valid_q;
	lrupr_pkg::occ_t  occ_q;
	lrupr_pkg::cnt_t  fault_q;
	lrupr_pkg::cnt_t  access_q;

	// Input and result registers.
	logic             valid_s1;
	lrupr_pkg::page_t page_s1;
	logic             valid_s2;
	logic             hit_s2;
	logic             ev_valid_s2;
	lrupr_pkg::page_t ev_page_s2;
	lrupr_pkg::cnt_t  fault_s2;
	lrupr_pkg::cnt_t  access_s2;
	lrupr_pkg::occ_t  occ_s2;

	// Handshake.
	logic s2_free;
	logic adv_s1;
	logic req_acc;

	// Lookup results.
	logic             found;
	lrupr_pkg::idx_t  found_idx;
	logic             free_found;
	lrupr_pkg::idx_t  free_idx;
	logic             lru_found;
	lrupr_pkg::idx_t  lru_idx;
	lrupr_pkg::rank_t lru_rank;
	lrupr_pkg::occ_t  cap_eff;
	logic             do_ins;
	logic             do_evict;
	logic             act;
	lrupr_pkg::idx_t  tgt_idx;
	lrupr_pkg::rank_t old_rank;
	lrupr_pkg::rank_t rank_n [N];
	lrupr_pkg::cnt_t  fault_n;
	lrupr_pkg::cnt_t  access_n;
	lrupr_pkg::occ_t  occ_n;
	lrupr_pkg::page_t ev_page_n;

	// APB port: zero-wait, register index from the word address.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == lrupr_pkg::REG_CAPACITY);
	assign prdata  = reg_sel ? lrupr_pkg::PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lrupr_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[lrupr_pkg::CAP_W-1:0];
		end
	end

	assign s2_free   = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign req_acc   = req.valid && req.ready;

	// Capacity is clamped to the range 1 to ENTRIES.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lrupr_pkg::OCC_W'(1);
		end else if (lrupr_pkg::OCC_W'(cap_q) > lrupr_pkg::OCC_W'(N) ||
				cap_q > lrupr_pkg::CAP_W'(N)) begin
			cap_eff = lrupr_pkg::OCC_W'(N);
		end else begin
			cap_eff = lrupr_pkg::OCC_W'(cap_q);
		end
	end

	// Parallel search; scanning downward leaves the lowest matching frame.
	// Valid ranks are distinct and run from 0 to occupancy-1, so the LRU frame is
	// the one whose rank equals occupancy-1.
	always_comb begin
		found      = 1'b0;
		found_idx  = '0;
		free_found = 1'b0;
		free_idx   = '0;
		lru_found  = 1'b0;
		lru_idx    = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (frame_valid_q[i] && frame_page_q[i] == page_s1) begin
				found     = 1'b1;
				found_idx = lrupr_pkg::IDX_W'(i);
			end
			if (!frame_valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = lrupr_pkg::IDX_W'(i);
			end
			if (frame_valid_q[i] &&
					rank_q[i] == lrupr_pkg::RANK_W'(occ_q - lrupr_pkg::OCC_W'(1))) begin
				lru_found = 1'b1;
				lru_idx   = lrupr_pkg::IDX_W'(i);
			end
		end
	end

	assign lru_rank  = rank_q[lru_idx];
	assign do_ins    = !found && (occ_q < cap_eff) && free_found;
	assign do_evict  = !found && !do_ins && lru_found;
	assign act       = found || do_ins || do_evict;
	assign tgt_idx   = found ? found_idx : (do_ins ? free_idx : lru_idx);
	assign old_rank  = found ? rank_q[found_idx] : lru_rank;
	assign ev_page_n = do_evict ? frame_page_q[lru_idx] : '0;

	// The touched frame goes to rank 0; frames more recent than its old rank age by
	// one. An insert ages every valid frame.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			if (act && tgt_idx == lrupr_pkg::IDX_W'(i)) begin
				rank_n[i] = '0;
			end else if (act && frame_valid_q[i] && (do_ins || rank_q[i] < old_rank)) begin
				rank_n[i] = rank_q[i] + lrupr_pkg::RANK_W'(1);
			end else begin
				rank_n[i] = rank_q[i];
			end
		end
	end

	assign access_n = (access_q == '1) ? access_q : access_q + lrupr_pkg::CNT_W'(1);
	assign fault_n  = (found || fault_q == '1) ? fault_q : fault_q + lrupr_pkg::CNT_W'(1);
	assign occ_n    = do_ins ? occ_q + lrupr_pkg::OCC_W'(1) : occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			occ_q         <= '0;
			fault_q       <= '0;
			access_q      <= '0;
			for (int i = 0; i < N; i++) begin
				frame_page_q[i] <= '0;
				rank_q[i]       <= '0;
			end
		end else if (adv_s1) begin
			occ_q    <= occ_n;
			fault_q  <= fault_n;
			access_q <= access_n;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= rank_n[i];
			end
			if (do_ins || do_evict) begin
				frame_page_q[tgt_idx] <= page_s1;
			end
			if (do_ins) begin
				frame_valid_q[tgt_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			page_s1 <= req.page;
		end
		if (adv_s1) begin
			hit_s2      <= found;
			ev_valid_s2 <= do_evict;
			ev_page_s2  <= ev_page_n;
			fault_s2    <= fault_n;
			access_s2   <= access_n;
			occ_s2      <= occ_n;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.hit           = hit_s2;
	assign rsp.evicted_valid = ev_valid_s2;
	assign rsp.evicted_page  = ev_page_s2;
	assign rsp.fault_count   = fault_s2;
	assign rsp.access_count  = access_s2;
	assign rsp.occupancy     = occ_s2;

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
		else $error("hit result also reports an eviction");

	// The occupancy count tracks the number of valid frames.
	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(frame_valid_q) == 32'(occ_q))
		else $error("occupancy count disagrees with valid frames");

	// A fault that does not evict fills one more frame.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !found && !do_evict) |=> occ_q == $past(occ_q) + lrupr_pkg::OCC_W'(1))
		else $error("fault without eviction did not add a frame");

	// Every reference finds a frame to touch.
	a_always_acts: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> act)
		else $error("reference neither hit, inserted nor evicted");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LRU page-replacement tracker, with its own LRU predictor.
module testbench;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		lrupr_pkg::page_t  evicted_page;
		lrupr_pkg::cnt_t   fault_count;
		lrupr_pkg::cnt_t   access_count;
		lrupr_pkg::occ_t   occupancy;
	} lookup_result_t;

	localparam logic [lrupr_pkg::PADDR_W-1:0] CAPACITY_ADDR =
		lrupr_pkg::PADDR_W'(4 * lrupr_pkg::REG_CAPACITY);
	localparam logic [lrupr_pkg::PADDR_W-1:0] UNMAPPED_ADDR =
		lrupr_pkg::PADDR_W'(4 * (lrupr_pkg::REG_CAPACITY + 1));

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lrupr_pkg::PADDR_W-1:0] paddr;
	logic [lrupr_pkg::PDATA_W-1:0] pwdata;
	logic [lrupr_pkg::PDATA_W-1:0] prdata;
	logic                          pready;

	lrupr_req_if req_ch ();
	lrupr_rsp_if rsp_ch ();

	// Predictor state.
	lrupr_pkg::cap_t  capacity_reg;
	lrupr_pkg::page_t resident_page [lrupr_pkg::ENTRIES];
	int               frame_rank [lrupr_pkg::ENTRIES];
	bit               frame_used [lrupr_pkg::ENTRIES];
	lrupr_pkg::cnt_t  fault_total;
	lrupr_pkg::cnt_t  access_total;

	lookup_result_t expected_results [$];
	int error_count;
	int send_idle_pct;
	int rsp_stall_pct;
	int hold_left = 0;
	event hold_start;

	lru_page_replacement u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lrupr_pkg::cnt_t sat_incr(lrupr_pkg::cnt_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Frames younger than the old rank of idx age by one; idx becomes the newest.
	function automatic void make_most_recent(int idx, int old_rank);
		for (int i = 0; i < lrupr_pkg::ENTRIES; i++) begin
			if (frame_used[i] && i != idx && frame_rank[i] < old_rank)
				frame_rank[i]++;
		end
		frame_rank[idx] = 0;
	endfunction

	function automatic lookup_result_t lru_lookup(lrupr_pkg::page_t p);
		lookup_result_t res;
		int limit;
		int held;
		int found;
		int free_idx;
		int lru_idx;
		int lru_rank;
		res      = '0;
		held     = 0;
		found    = -1;
		free_idx = -1;
		lru_idx  = -1;
		lru_rank = 0;
		limit = (capacity_reg == 0) ? 1 :
			((capacity_reg > lrupr_pkg::ENTRIES) ? lrupr_pkg::ENTRIES : int'(capacity_reg));
		for (int i = 0; i < lrupr_pkg::ENTRIES; i++) begin
			if (frame_used[i]) begin
				held++;
				if (found < 0 && resident_page[i] == p)
					found = i;
				if (lru_idx < 0 || frame_rank[i] > lru_rank) begin
					lru_idx  = i;
					lru_rank = frame_rank[i];
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		access_total = sat_incr(access_total);
		if (found >= 0) begin
			res.hit = 1'b1;
			make_most_recent(found, frame_rank[found]);
		end else begin
			fault_total = sat_incr(fault_total);
			if (held < limit && free_idx >= 0) begin
				frame_used[free_idx]    = 1'b1;
				resident_page[free_idx] = p;
				make_most_recent(free_idx, lrupr_pkg::ENTRIES + 1);
				held++;
			end else if (lru_idx >= 0) begin
				// Full, or capacity was lowered below occupancy: replace in place.
				res.evicted_valid      = 1'b1;
				res.evicted_page       = resident_page[lru_idx];
				resident_page[lru_idx] = p;
				make_most_recent(lru_idx, lru_rank);
			end
		end
		res.fault_count  = fault_total;
		res.access_count = access_total;
		res.occupancy    = lrupr_pkg::occ_t'(held);
		return res;
	endfunction

	task automatic send_page(lrupr_pkg::page_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.page  <= p;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		expected_results.insert(expected_results.size(), lru_lookup(p));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic apb_access(logic [lrupr_pkg::PADDR_W-1:0] addr, logic write,
			logic [lrupr_pkg::PDATA_W-1:0] wdata,
			output logic [lrupr_pkg::PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (write && addr[lrupr_pkg::PADDR_W-1:2] == lrupr_pkg::REG_CAPACITY)
			capacity_reg = wdata[lrupr_pkg::CAP_W-1:0];
	endtask

	task automatic check_capacity_reg();
		logic [lrupr_pkg::PDATA_W-1:0] rd;
		apb_access(CAPACITY_ADDR, 1'b0, '0, rd);
		if (rd[lrupr_pkg::CAP_W-1:0] !== capacity_reg) begin
			error_count++;
			$display("%0t: capacity read mismatch, expected %0d, got %0d",
				$time, capacity_reg, rd[lrupr_pkg::CAP_W-1:0]);
		end
	endtask

	// Bits above the register width carry noise and must be ignored.
	task automatic set_capacity(lrupr_pkg::cap_t cap);
		logic [lrupr_pkg::PDATA_W-1:0] rd;
		wait_idle();
		apb_access(CAPACITY_ADDR, 1'b1,
			($urandom & ~lrupr_pkg::PDATA_W'(2 ** lrupr_pkg::CAP_W - 1)) |
			lrupr_pkg::PDATA_W'(cap), rd);
		check_capacity_reg();
	endtask

	task automatic test_register_access();
		logic [lrupr_pkg::PDATA_W-1:0] rd;
		check_capacity_reg();
		set_capacity(0);
		apb_access(UNMAPPED_ADDR, 1'b1, '1, rd);
		check_capacity_reg();
	endtask

	task automatic test_directed_references();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		// Capacity zero acts as one frame; page zero must fault on an empty store.
		send_page(0);
		send_page(0);
		send_page(127);
		set_capacity(1);
		send_page(85);
		send_page(85);
		send_page(42);
		set_capacity(3);
		send_page(1);
		send_page(2);
		send_page(42);
		send_page(3);
		send_page(2);
		// Shrinking below occupancy keeps all three frames resident.
		set_capacity(2);
		send_page(100);
		send_page(42);
		send_page(127);
	endtask

	task automatic test_random_traffic();
		lrupr_pkg::cap_t  caps [8];
		lrupr_pkg::page_t recent [$];
		lrupr_pkg::page_t p;
		int               base;
		int               roll;
		caps    = '{6, 12, 17, 16, 0, 31, 1, 0};
		caps[7] = lrupr_pkg::cap_t'($urandom_range(31));
		for (int ph = 0; ph < 8; ph++) begin
			set_capacity(caps[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
				default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
			endcase
			// Mostly a narrow working set and re-references, so hits are common.
			base = $urandom_range(127);
			repeat (90) begin
				roll = $urandom_range(99);
				if (roll < 55)
					p = lrupr_pkg::page_t'(base + $urandom_range(19));
				else if (roll < 80 && recent.size() != 0)
					p = recent[$urandom_range(recent.size() - 1)];
				else
					p = lrupr_pkg::page_t'($urandom_range(127));
				send_page(p);
				recent.insert(recent.size(), p);
				if (recent.size() > 8)
					void'(recent.pop_front());
			end
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		-> hold_start;
		repeat (30)
			send_page(lrupr_pkg::page_t'($urandom_range(127)));
	endtask

	// The long receiver hold-off is counted down here, one step per cycle.
	initial begin
		forever begin
			@(hold_start);
			hold_left <= 60;
			repeat (60) begin
				@(posedge clk);
				hold_left <= hold_left - 1;
			end
		end
	end

	initial begin
		lookup_result_t want;
		lookup_result_t got;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got = {rsp_ch.hit, rsp_ch.evicted_valid, rsp_ch.evicted_page,
					rsp_ch.fault_count, rsp_ch.access_count, rsp_ch.occupancy};
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: result with no request outstanding, got hit=%0b", $time,
						got.hit);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: expected hit=%0b evicted=%0b/%0d faults=%0d accesses=%0d occupancy=%0d",
							$time, want.hit, want.evicted_valid, want.evicted_page,
							want.fault_count, want.access_count, want.occupancy);
						$display("%0t: actual   hit=%0b evicted=%0b/%0d faults=%0d accesses=%0d occupancy=%0d",
							$time, got.hit, got.evicted_valid, got.evicted_page,
							got.fault_count, got.access_count, got.occupancy);
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.page   = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		error_count   = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		capacity_reg  = lrupr_pkg::CAP_RESET;
		fault_total   = '0;
		access_total  = '0;
		for (int i = 0; i < lrupr_pkg::ENTRIES; i++) begin
			resident_page[i] = '0;
			frame_rank[i]    = 0;
			frame_used[i]    = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_references();
		test_random_traffic();
		test_backpressure();
		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
